// ===== design/assert_macros.svh =====
// Assertion macros used by the statement classifier top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SSTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define SSTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/sstc_pkg.sv =====
// Types, token codes and the keyword sequence table of the statement classifier.
package sstc_pkg;

  localparam int unsigned PREFIX_DEPTH = 9;
  localparam int unsigned ROM_SIZE     = 27;
  localparam int unsigned ROM_WIDTH    = 8;
  localparam int unsigned CNT_W        = $clog2(PREFIX_DEPTH + 1);
  localparam int unsigned COL_W        = $clog2(ROM_WIDTH);
  localparam int unsigned CMP_W        = (CNT_W > 4) ? CNT_W : 4;

  // token kinds
  localparam logic [5:0] K_NONE      = 6'd0;
  localparam logic [5:0] K_DECLARE   = 6'd1;
  localparam logic [5:0] K_FUNCTION  = 6'd2;
  localparam logic [5:0] K_PROCEDURE = 6'd3;
  localparam logic [5:0] K_PACKAGE   = 6'd4;
  localparam logic [5:0] K_BODY      = 6'd5;
  localparam logic [5:0] K_BEGIN     = 6'd6;
  localparam logic [5:0] K_SEMI      = 6'd19;
  localparam logic [5:0] K_CREATE    = 6'd33;
  localparam logic [5:0] K_LESS      = 6'd40;
  localparam logic [5:0] K_TRIGGER   = 6'd42;
  localparam logic [5:0] K_TYPE      = 6'd43;
  localparam logic [5:0] K_OR        = 6'd44;
  localparam logic [5:0] K_REPLACE   = 6'd45;
  localparam logic [5:0] K_DOT       = 6'd46;
  localparam logic [5:0] K_COLON     = 6'd47;
  localparam logic [5:0] K_EQUAL     = 6'd48;
  localparam logic [5:0] K_COMPOUND  = 6'd49;
  localparam logic [5:0] K_JAVA      = 6'd50;
  localparam logic [5:0] K_SOURCE    = 6'd51;
  localparam logic [5:0] K_AND       = 6'd52;
  localparam logic [5:0] K_COMPILE   = 6'd53;
  localparam logic [5:0] K_NAMED     = 6'd54;
  localparam logic [5:0] K_WITH      = 6'd55;
  localparam logic [5:0] K_COMMENT   = 6'd56;
  localparam logic [5:0] K_EOL       = 6'd57;
  localparam logic [5:0] K_EOS       = 6'd58;
  localparam logic [5:0] K_EOF       = 6'd59;

  // statement types
  localparam logic [3:0] ST_SQL         = 4'd0;
  localparam logic [3:0] ST_WITH        = 4'd1;
  localparam logic [3:0] ST_BLOCK       = 4'd2;
  localparam logic [3:0] ST_FUNCTION    = 4'd3;
  localparam logic [3:0] ST_PROCEDURE   = 4'd4;
  localparam logic [3:0] ST_PACKAGE     = 4'd5;
  localparam logic [3:0] ST_PACKAGE_BDY = 4'd6;
  localparam logic [3:0] ST_TRIGGER     = 4'd7;
  localparam logic [3:0] ST_TYPE        = 4'd8;
  localparam logic [3:0] ST_TYPE_BODY   = 4'd9;
  localparam logic [3:0] ST_JAVA        = 4'd10;
  localparam logic [3:0] ST_JAVA_SOURCE = 4'd11;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_NAME    = 2'd1,
    PH_PENDING = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [5:0]  token_kind;
    logic [15:0] token_line;
    logic [11:0] token_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  statement_type;
    logic        needs_closing_semicolon;
    logic        may_have_errors;
    logic        name_valid;
    logic        owner_valid;
    logic [15:0] owner_line;
    logic [11:0] owner_offset;
    logic [15:0] name_line;
    logic [11:0] name_offset;
    logic        bind_variable;
    logic [5:0]  end_kind;
  } out_t;

  localparam logic [5:0] ROM_TOK [ROM_SIZE][ROM_WIDTH] = '{
    '{K_WITH, K_PROCEDURE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_WITH, K_FUNCTION, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_LESS, K_LESS, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_DECLARE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_BEGIN, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_FUNCTION, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_PACKAGE, K_BODY, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_PACKAGE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_PROCEDURE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_TRIGGER, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_TYPE, K_BODY, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_TYPE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_FUNCTION, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_PACKAGE, K_BODY, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_PACKAGE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_PROCEDURE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_TRIGGER, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_TYPE, K_BODY, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_TYPE, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_AND, K_COMPILE, K_JAVA, K_SOURCE, K_NAMED},
    '{K_CREATE, K_OR, K_REPLACE, K_JAVA, K_SOURCE, K_NAMED, K_NONE, K_NONE},
    '{K_CREATE, K_AND, K_COMPILE, K_JAVA, K_SOURCE, K_NAMED, K_NONE, K_NONE},
    '{K_CREATE, K_JAVA, K_SOURCE, K_NAMED, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_AND, K_COMPILE, K_JAVA, K_NONE, K_NONE},
    '{K_CREATE, K_OR, K_REPLACE, K_JAVA, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_AND, K_COMPILE, K_JAVA, K_NONE, K_NONE, K_NONE, K_NONE},
    '{K_CREATE, K_JAVA, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE}
  };

  localparam logic [3:0] ROM_LEN [ROM_SIZE] = '{
    4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd2, 4'd3, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2, 4'd4, 4'd5,
    4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd8, 4'd6, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4, 4'd2
  };

  localparam logic [3:0] ROM_TYPE [ROM_SIZE] = '{
    ST_WITH, ST_WITH, ST_BLOCK, ST_BLOCK, ST_BLOCK, ST_FUNCTION, ST_PACKAGE_BDY,
    ST_PACKAGE, ST_PROCEDURE, ST_TRIGGER, ST_TYPE_BODY, ST_TYPE, ST_FUNCTION,
    ST_PACKAGE_BDY, ST_PACKAGE, ST_PROCEDURE, ST_TRIGGER, ST_TYPE_BODY, ST_TYPE,
    ST_JAVA_SOURCE, ST_JAVA_SOURCE, ST_JAVA_SOURCE, ST_JAVA_SOURCE,
    ST_JAVA, ST_JAVA, ST_JAVA, ST_JAVA
  };

endpackage

// ===== design/sstc_core.sv =====
// Statement state and per-token update: sequence match, name capture, terminator watch.
module sstc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  sstc_pkg::in_t item,
  output sstc_pkg::out_t result
);

  sstc_pkg::phase_t               phase_r, phase_nxt;
  logic [3:0]                     type_r, type_nxt;
  logic [sstc_pkg::ROM_SIZE-1:0]  alive_r, alive_nxt;
  logic [sstc_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                           first_vld_r, first_vld_nxt;
  logic [15:0]                    first_line_r, first_line_nxt;
  logic [11:0]                    first_off_r, first_off_nxt;
  logic                           second_vld_r, second_vld_nxt;
  logic [15:0]                    second_line_r, second_line_nxt;
  logic [11:0]                    second_off_r, second_off_nxt;
  logic [5:0]                     prev_r, prev_nxt;
  logic [5:0]                     term_r, term_nxt;

  logic [sstc_pkg::ROM_SIZE-1:0]  cand;
  logic [sstc_pkg::ROM_SIZE-1:0]  exact;
  logic [3:0]                     exact_type;
  logic                           pushed;
  logic                           bind_hit;
  logic [5:0]                     kind;

  assign kind   = item.token_kind;
  assign pushed = count_r < sstc_pkg::CNT_W'(sstc_pkg::PREFIX_DEPTH);

  // Sequences still alive after this token, and those already complete without it.
  always_comb begin
    exact_type = sstc_pkg::ST_SQL;
    for (int i = 0; i < sstc_pkg::ROM_SIZE; i++) begin
      cand[i]  = alive_r[i] && pushed &&
                 (sstc_pkg::CMP_W'(sstc_pkg::ROM_LEN[i]) > sstc_pkg::CMP_W'(count_r)) &&
                 (sstc_pkg::ROM_TOK[i][count_r[sstc_pkg::COL_W-1:0]] == kind);
      exact[i] = alive_r[i] &&
                 (sstc_pkg::CMP_W'(sstc_pkg::ROM_LEN[i]) == sstc_pkg::CMP_W'(count_r));
      exact_type = exact_type | (exact[i] ? sstc_pkg::ROM_TYPE[i] : 4'd0);
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    type_nxt        = type_r;
    alive_nxt       = alive_r;
    count_nxt       = count_r;
    first_vld_nxt   = first_vld_r;
    first_line_nxt  = first_line_r;
    first_off_nxt   = first_off_r;
    second_vld_nxt  = second_vld_r;
    second_line_nxt = second_line_r;
    second_off_nxt  = second_off_r;
    prev_nxt        = prev_r;
    term_nxt        = term_r;
    bind_hit        = 1'b0;
    if (en) begin
      if (item.mode) begin
        phase_nxt      = sstc_pkg::PH_TYPE;
        type_nxt       = sstc_pkg::ST_SQL;
        alive_nxt      = '1;
        count_nxt      = '0;
        first_vld_nxt  = 1'b0;
        second_vld_nxt = 1'b0;
        prev_nxt       = sstc_pkg::K_NONE;
        term_nxt       = sstc_pkg::K_NONE;
      end else if (kind != sstc_pkg::K_COMMENT) begin
        bind_hit = (prev_r == sstc_pkg::K_COLON) && (kind != sstc_pkg::K_EQUAL);
        prev_nxt = kind;
        case (phase_r)
          sstc_pkg::PH_TYPE: begin
            if (type_r == sstc_pkg::ST_SQL && kind != sstc_pkg::K_EOL) begin
              if (|cand) begin
                alive_nxt = cand;
                count_nxt = count_r + sstc_pkg::CNT_W'(1);
              end else if (|exact) begin
                // the breaking token becomes the first name token
                type_nxt       = exact_type;
                phase_nxt      = sstc_pkg::PH_NAME;
                first_vld_nxt  = kind != sstc_pkg::K_NONE;
                first_line_nxt = item.token_line;
                first_off_nxt  = item.token_offset;
              end else begin
                phase_nxt = sstc_pkg::PH_PENDING;
              end
            end
          end
          sstc_pkg::PH_NAME: begin
            if (!first_vld_r) begin
              first_vld_nxt  = kind != sstc_pkg::K_NONE;
              first_line_nxt = item.token_line;
              first_off_nxt  = item.token_offset;
            end else if (kind != sstc_pkg::K_DOT && prev_r == sstc_pkg::K_DOT) begin
              second_vld_nxt  = kind != sstc_pkg::K_NONE;
              second_line_nxt = item.token_line;
              second_off_nxt  = item.token_offset;
            end else if (kind != sstc_pkg::K_DOT) begin
              phase_nxt = sstc_pkg::PH_PENDING;
            end
          end
          sstc_pkg::PH_PENDING: begin
            if (type_r == sstc_pkg::ST_SQL) begin
              if (kind == sstc_pkg::K_SEMI || kind == sstc_pkg::K_EOS) begin
                phase_nxt = sstc_pkg::PH_DONE;
                term_nxt  = kind;
              end
            end else if (type_r == sstc_pkg::ST_WITH) begin
              if (kind == sstc_pkg::K_EOS) begin
                phase_nxt = sstc_pkg::PH_DONE;
                term_nxt  = kind;
              end
            end else if (kind == sstc_pkg::K_EOF || kind == sstc_pkg::K_EOS) begin
              phase_nxt = sstc_pkg::PH_DONE;
              term_nxt  = kind;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sstc_pkg::PH_TYPE;
      type_r       <= sstc_pkg::ST_SQL;
      alive_r      <= '1;
      count_r      <= '0;
      first_vld_r  <= 1'b0;
      second_vld_r <= 1'b0;
      prev_r       <= sstc_pkg::K_NONE;
      term_r       <= sstc_pkg::K_NONE;
    end else begin
      phase_r      <= phase_nxt;
      type_r       <= type_nxt;
      alive_r      <= alive_nxt;
      count_r      <= count_nxt;
      first_vld_r  <= first_vld_nxt;
      second_vld_r <= second_vld_nxt;
      prev_r       <= prev_nxt;
      term_r       <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_line_r  <= first_line_nxt;
    first_off_r   <= first_off_nxt;
    second_line_r <= second_line_nxt;
    second_off_r  <= second_off_nxt;
  end

  // Report the state as it stands after this token.
  always_comb begin
    result                         = '0;
    result.phase                   = phase_nxt;
    result.statement_type          = type_nxt;
    result.needs_closing_semicolon = (type_nxt >= sstc_pkg::ST_BLOCK) &&
                                     (type_nxt <= sstc_pkg::ST_TYPE_BODY);
    result.may_have_errors         = (type_nxt >= sstc_pkg::ST_FUNCTION) &&
                                     (type_nxt <= sstc_pkg::ST_JAVA_SOURCE);
    if (second_vld_nxt) begin
      result.name_valid   = 1'b1;
      result.owner_valid  = 1'b1;
      result.owner_line   = first_line_nxt;
      result.owner_offset = first_off_nxt;
      result.name_line    = second_line_nxt;
      result.name_offset  = second_off_nxt;
    end else if (first_vld_nxt) begin
      result.name_valid  = 1'b1;
      result.name_line   = first_line_nxt;
      result.name_offset = first_off_nxt;
    end
    result.bind_variable = bind_hit;
    result.end_kind      = (phase_nxt == sstc_pkg::PH_DONE) ? term_nxt : sstc_pkg::K_NONE;
  end

endmodule

// ===== design/sql_statement_type_classifier.sv =====
// Top level of the SQL statement type classifier: beat registers around the classifier core.
// Classifies one SQL / PL-SQL statement from its lexed tokens, one token beat per clock
// cycle sustained while the output is not stalled; each token beat gives one result beat
// through the input register, then the result register. The rate is set by the state
// update, which compares the token against all 27 keyword sequences in parallel.
// Mode 1 clears the statement state; comment tokens leave it untouched. The input side
// keeps taking beats while a result waits on a stalled output, until both registers hold.
`include "assert_macros.svh"

module sql_statement_type_classifier (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sstc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sstc_pkg::out_t out_data
);

  logic           in_vld_r, in_vld_nxt;
  sstc_pkg::in_t  in_r;
  logic           out_vld_r, out_vld_nxt;
  sstc_pkg::out_t out_r;
  sstc_pkg::out_t result;
  logic           adv;
  logic           take;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

  sstc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .item   (in_r),
    .result (result)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `SSTC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "beat after reset")
  `SSTC_ASSERT(a_adv_gives_result, adv |=> out_valid, "result beat lost")
  `SSTC_ASSERT(a_end_only_done, out_valid && out_data.end_kind != sstc_pkg::K_NONE |-> out_data.phase == sstc_pkg::PH_DONE, "end kind outside completed phase")
  `SSTC_ASSERT(a_owner_has_name, out_valid && out_data.owner_valid |-> out_data.name_valid, "owner without name")
  `SSTC_ASSERT(a_type_phase_sql, out_valid && out_data.phase == sstc_pkg::PH_TYPE |-> out_data.statement_type == sstc_pkg::ST_SQL && !out_data.name_valid, "type set during recognition")

endmodule
